// ===== design/svf_pkg.sv =====
// ----------------------------------------------------------------------------
// svf_pkg
// Shared types and constants for the sliding-window velocity fit core.
// ----------------------------------------------------------------------------
package svf_pkg;

    localparam int MAX_WINDOW_DEF = 16;
    localparam int WIN_MIN        = 2;
    localparam logic [4:0] WIN_RESET = 5'd16;

    localparam int POS_W   = 32;
    localparam int STAMP_W = 40;
    localparam int VEL_W   = 32;
    localparam int HELD_W  = 5;
    localparam int CFG_W   = 5;

    localparam int ACC_W   = 128;   // sums and products, two's complement
    localparam int MP_W    = 64;    // serial multiplier operand width
    localparam int STEP_W  = 6;     // counts MP_W serial steps
    localparam logic [STEP_W-1:0] STEP_LAST = 6'd63;
    localparam logic [MP_W-1:0]   SCALE     = 64'd1000000;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // input word action codes
    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T0_RD,
        ST_T0_LD,
        ST_S_RD,
        ST_S_LD,
        ST_S_MUL,
        ST_F1_LD,
        ST_F1_MUL,
        ST_F2_LD,
        ST_F2_MUL,
        ST_F3_LD,
        ST_F3_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       push;       // store sample, update ring
        logic       clr;        // empty the window
        logic       ld_t0;      // latch oldest stamp
        logic       ld_sample;  // load lanes from read word
        logic       mul_step;   // one serial multiply step
        logic       mul_top;    // step on the multiplier sign bit
        logic       mul_sub;    // subtract product from accumulator
        logic       lane0_en;   // lane 0 takes part in the step
        logic       ld_f1;      // n * sums
        logic       ld_f2;      // minus st * sums
        logic       ld_f3;      // numerators times scale
        logic       div_start;
        logic [1:0] axis;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic few;       // fewer than two samples held
        logic last;      // current index is the newest sample
        logic den_bad;   // denominator zero or negative
        logic div_done;
        logic out_busy;  // output word waiting and stalled
    } stat_t;

endpackage

// ===== design/svf_ram.sv =====
// ----------------------------------------------------------------------------
// svf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module svf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/svf_div.sv =====
// ----------------------------------------------------------------------------
// svf_div
// Signed restoring divider, one quotient bit per cycle, saturated to 32 bits.
// ----------------------------------------------------------------------------
module svf_div
    import svf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [ACC_W-1:0] num,
    input  logic [ACC_W-1:0] den,
    output logic             done,
    output logic [VEL_W-1:0] q
);

    localparam int CNT_W = $clog2(ACC_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ACC_W - 1);
    localparam logic [ACC_W-1:0] NEG_LIM  = ACC_W'(64'h8000_0000);
    localparam logic [ACC_W-1:0] POS_LIM  = ACC_W'(64'h7FFF_FFFF);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [ACC_W-1:0] n_reg, n_next;
    logic [ACC_W-1:0] r_reg, r_next;
    logic [ACC_W-1:0] q_reg, q_next;
    logic [ACC_W-1:0] den_reg, den_next;
    logic [ACC_W-1:0] r_sh;
    logic             fits;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        n_next    = n_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        r_sh      = {r_reg[ACC_W-2:0], n_reg[ACC_W-1]};
        fits      = (r_sh >= den_reg);
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = num[ACC_W-1];
            n_next    = num[ACC_W-1] ? (~num + ACC_W'(1)) : num;
            r_next    = '0;
            q_next    = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            r_next   = fits ? (r_sh - den_reg) : r_sh;
            q_next   = {q_reg[ACC_W-2:0], fits};
            n_next   = {n_reg[ACC_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        n_reg   <= n_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    always_comb
    begin
        if (neg_reg)
        begin
            q = (q_reg > NEG_LIM) ? 32'h8000_0000 : (~q_reg[VEL_W-1:0] + VEL_W'(1));
        end
        else
        begin
            q = (q_reg > POS_LIM) ? 32'h7FFF_FFFF : q_reg[VEL_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

// ===== design/svf_dp.sv =====
// ----------------------------------------------------------------------------
// svf_dp
// Datapath: sample ring, four serial multiply-accumulate lanes, divider and
// output word register.
// ----------------------------------------------------------------------------
module svf_dp
    import svf_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    input  logic [$clog2(MAX_WINDOW)-1:0] idx,
    output stat_t                         stat,
    input  logic                          cfg_write_en,
    input  logic [CFG_W-1:0]              cfg_write_data,
    input  logic signed [POS_W-1:0]       pos_x,
    input  logic signed [POS_W-1:0]       pos_y,
    input  logic signed [POS_W-1:0]       pos_z,
    input  logic [STAMP_W-1:0]            stamp_us,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VEL_W-1:0]       vel_x,
    output logic signed [VEL_W-1:0]       vel_y,
    output logic signed [VEL_W-1:0]       vel_z,
    output logic                          fit_valid,
    output logic [HELD_W-1:0]             samples_held
);

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int RW = 3 * POS_W + STAMP_W;
    localparam logic [31:0] MAXW = 32'(MAX_WINDOW);

    logic [CFG_W-1:0] ws_reg;
    logic [AW-1:0]    oldest_reg;
    logic [CW-1:0]    fill_reg;
    logic [STAMP_W-1:0] t0_reg;
    logic [ACC_W-1:0] mc_reg [4];
    logic [ACC_W-1:0] acc_reg [4];
    logic [MP_W-1:0]  mp_reg;
    logic [MP_W-1:0]  st_reg;
    logic [MP_W-1:0]  sp_reg [3];
    logic [VEL_W-1:0] vel_reg [3];
    logic             fit_reg;
    logic             ov_reg;
    logic [VEL_W-1:0] ovx_reg, ovy_reg, ovz_reg;
    logic             ofit_reg;
    logic [HELD_W-1:0] oheld_reg;

    // ring bookkeeping for a push
    logic [31:0] eff32, fill32, old32, fadj32, slot32, ra32, ws32;
    logic [RW-1:0] rdata;
    logic [STAMP_W-1:0] r_stamp;
    logic [POS_W-1:0]   r_p [3];
    logic [STAMP_W:0]   tdiff;
    logic [MP_W-1:0]    t64;
    logic               div_done;
    logic [VEL_W-1:0]   div_q;

    always_comb
    begin
        ws32   = 32'(ws_reg);
        eff32  = (ws32 < 32'(WIN_MIN)) ? 32'(WIN_MIN) : ((ws32 > MAXW) ? MAXW : ws32);
        fill32 = 32'(fill_reg);
        old32  = 32'(oldest_reg);
        fadj32 = fill32;
        if (fill32 >= eff32)
        begin
            old32  = 32'(oldest_reg) + (fill32 - eff32 + 32'd1);
            if (old32 >= MAXW)
            begin
                old32 = old32 - MAXW;
            end
            fadj32 = eff32 - 32'd1;
        end
        slot32 = old32 + fadj32;
        if (slot32 >= MAXW)
        begin
            slot32 = slot32 - MAXW;
        end
        ra32 = 32'(oldest_reg) + 32'(idx);
        if (ra32 >= MAXW)
        begin
            ra32 = ra32 - MAXW;
        end
    end

    svf_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_WINDOW)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (AW'(slot32)),
        .wdata ({stamp_us, pos_z, pos_y, pos_x}),
        .raddr (AW'(ra32)),
        .rdata (rdata)
    );

    assign r_p[0]  = rdata[POS_W-1:0];
    assign r_p[1]  = rdata[2*POS_W-1:POS_W];
    assign r_p[2]  = rdata[3*POS_W-1:2*POS_W];
    assign r_stamp = rdata[RW-1:3*POS_W];
    assign tdiff   = {1'b0, r_stamp} - {1'b0, t0_reg};
    assign t64     = MP_W'(signed'(tdiff));

    svf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (acc_reg[32'(cmd.axis) + 1]),
        .den   (acc_reg[0]),
        .done  (div_done),
        .q     (div_q)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg     <= WIN_RESET;
            oldest_reg <= '0;
            fill_reg   <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                ws_reg <= cfg_write_data;
            end
            if (cmd.clr)
            begin
                oldest_reg <= '0;
                fill_reg   <= '0;
            end
            else if (cmd.push)
            begin
                oldest_reg <= AW'(old32);
                fill_reg   <= CW'(fadj32 + 32'd1);
            end
            if (cmd.out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // arithmetic lanes: 0 = t*t / den, 1..3 = t*p per axis
    always_ff @(posedge clk)
    begin
        if (cmd.push || cmd.clr)
        begin
            for (int k = 0; k < 4; k++)
            begin
                acc_reg[k] <= '0;
            end
            for (int k = 0; k < 3; k++)
            begin
                sp_reg[k]  <= '0;
                vel_reg[k] <= '0;
            end
            st_reg  <= '0;
            fit_reg <= 1'b0;
        end
        if (cmd.ld_t0)
        begin
            t0_reg <= r_stamp;
        end
        if (cmd.ld_sample)
        begin
            mc_reg[0] <= ACC_W'(signed'(t64));
            for (int k = 0; k < 3; k++)
            begin
                mc_reg[k+1] <= ACC_W'(signed'(r_p[k]));
                sp_reg[k]   <= sp_reg[k] + MP_W'(signed'(r_p[k]));
            end
            st_reg <= st_reg + t64;
            mp_reg <= t64;
        end
        if (cmd.mul_step)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if ((k != 0) || cmd.lane0_en)
                begin
                    if (mp_reg[0])
                    begin
                        if (cmd.mul_sub ^ cmd.mul_top)
                        begin
                            acc_reg[k] <= acc_reg[k] - mc_reg[k];
                        end
                        else
                        begin
                            acc_reg[k] <= acc_reg[k] + mc_reg[k];
                        end
                    end
                end
                mc_reg[k] <= {mc_reg[k][ACC_W-2:0], 1'b0};
            end
            mp_reg <= {1'b0, mp_reg[MP_W-1:1]};
        end
        if (cmd.ld_f1)
        begin
            for (int k = 0; k < 4; k++)
            begin
                mc_reg[k]  <= acc_reg[k];
                acc_reg[k] <= '0;
            end
            mp_reg <= MP_W'(fill_reg);
        end
        if (cmd.ld_f2)
        begin
            mc_reg[0] <= ACC_W'(signed'(st_reg));
            for (int k = 0; k < 3; k++)
            begin
                mc_reg[k+1] <= ACC_W'(signed'(sp_reg[k]));
            end
            mp_reg <= st_reg;
        end
        if (cmd.ld_f3)
        begin
            for (int k = 1; k < 4; k++)
            begin
                mc_reg[k]  <= acc_reg[k];
                acc_reg[k] <= '0;
            end
            mp_reg  <= SCALE;
            fit_reg <= 1'b1;
        end
        if (div_done)
        begin
            vel_reg[cmd.axis] <= div_q;
        end
        if (cmd.out_load)
        begin
            ovx_reg   <= vel_reg[0];
            ovy_reg   <= vel_reg[1];
            ovz_reg   <= vel_reg[2];
            ofit_reg  <= fit_reg;
            oheld_reg <= HELD_W'(fill_reg);
        end
    end

    always_comb
    begin
        stat.few      = (fill32 < 32'(WIN_MIN));
        stat.last     = ((32'(idx) + 32'd1) == fill32);
        stat.den_bad  = (acc_reg[0] == '0) || acc_reg[0][ACC_W-1];
        stat.div_done = div_done;
        stat.out_busy = ov_reg && out_stall;
    end

    assign out_valid    = ov_reg;
    assign vel_x        = ovx_reg;
    assign vel_y        = ovy_reg;
    assign vel_z        = ovz_reg;
    assign fit_valid    = ofit_reg;
    assign samples_held = oheld_reg;

`ifndef SYNTHESIS
    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= MAXW)
        else $error("fill count above window depth");
    a_oldest_rng: assert property (@(posedge clk) disable iff (!rst_n)
        32'(oldest_reg) < MAXW)
        else $error("oldest slot out of range");
    a_clr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr |=> (fill_reg == '0) && (oldest_reg == '0))
        else $error("clear left samples in the window");
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && !cmd.clr) |=> (fill_reg != '0))
        else $error("push left the window empty");
`endif

endmodule

// ===== design/svf_ctrl.sv =====
// ----------------------------------------------------------------------------
// svf_ctrl
// Sequencer: accept, sample walk, serial multiply phases, three divisions.
// ----------------------------------------------------------------------------
module svf_ctrl
    import svf_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  stat_t                         stat,
    output cmd_t                          cmd,
    output logic [$clog2(MAX_WINDOW)-1:0] idx
);

    localparam int AW = $clog2(MAX_WINDOW);

    state_t            state_reg, state_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        axis_reg, axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            step_reg  <= '0;
            axis_reg  <= AXIS_X;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        step_next    = step_reg;
        axis_next    = axis_reg;
        cmd          = '0;
        cmd.lane0_en = 1'b1;
        cmd.axis     = axis_reg;
        cmd.mul_top  = (step_reg == STEP_LAST);
        in_stall     = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                idx_next  = '0;
                axis_next = AXIS_X;
                if (in_valid)
                begin
                    if (action == ACT_CLEAR)
                    begin
                        cmd.clr    = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.push   = 1'b1;
                        state_next = ST_T0_RD;
                    end
                end
            end
            ST_T0_RD:
            begin
                state_next = stat.few ? ST_DONE : ST_T0_LD;
            end
            ST_T0_LD:
            begin
                cmd.ld_t0  = 1'b1;
                state_next = ST_S_RD;
            end
            ST_S_RD:
            begin
                state_next = ST_S_LD;
            end
            ST_S_LD:
            begin
                cmd.ld_sample = 1'b1;
                step_next     = '0;
                state_next    = ST_S_MUL;
            end
            ST_S_MUL:
            begin
                cmd.mul_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    if (stat.last)
                    begin
                        state_next = ST_F1_LD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_S_RD;
                    end
                end
            end
            ST_F1_LD:
            begin
                cmd.ld_f1  = 1'b1;
                step_next  = '0;
                state_next = ST_F1_MUL;
            end
            ST_F1_MUL:
            begin
                cmd.mul_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_F2_LD;
                end
            end
            ST_F2_LD:
            begin
                cmd.ld_f2  = 1'b1;
                step_next  = '0;
                state_next = ST_F2_MUL;
            end
            ST_F2_MUL:
            begin
                cmd.mul_step = 1'b1;
                cmd.mul_sub  = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_F3_LD;
                end
            end
            ST_F3_LD:
            begin
                if (stat.den_bad)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.ld_f3  = 1'b1;
                    step_next  = '0;
                    state_next = ST_F3_MUL;
                end
            end
            ST_F3_MUL:
            begin
                cmd.mul_step = 1'b1;
                cmd.lane0_en = 1'b0;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    if (axis_reg == AXIS_Z)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idx = idx_reg;

endmodule

// ===== design/sliding_window_velocity_fit_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_velocity_fit_core
// Least-squares velocity fit over a sliding window of timestamped 3-D samples.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one word per sample or clear command.
//    action = 0 pushes pos_x/y/z (Q16.16) with stamp_us and fits; action = 1
//    empties the window. Every accepted word yields exactly one output word.
//  - Output channel (out_valid / out_stall): vel_x/y/z (Q16.16 m/s, saturated),
//    fit_valid and samples_held. The word sits in an output register until taken.
//  - cfg_write_en / cfg_write_data set window_size (clamped to 2..MAX_WINDOW);
//    write only while idle.
//  - A clear, or a push leaving one sample, goes straight to the output
//    register; a fit over n samples runs one 64-step serial multiply per
//    sample, three 64-step sum passes and three restoring divides on one
//    divider; a non-positive denominator skips the last pass and the divides.
//  - One item is in flight at a time; in_stall is high from accept until the
//    result is placed in the output register.
//  - A stalled output holds its word; a finished result waits until the
//    register frees, then the next input is taken.
//  - Reset (rst_n low, async) empties the window and sets window_size to 16.
// ----------------------------------------------------------------------------
module sliding_window_velocity_fit_core
    import svf_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write_en,
    input  logic [CFG_W-1:0]        cfg_write_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    action,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [POS_W-1:0] pos_z,
    input  logic [STAMP_W-1:0]      stamp_us,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [VEL_W-1:0] vel_x,
    output logic signed [VEL_W-1:0] vel_y,
    output logic signed [VEL_W-1:0] vel_z,
    output logic                    fit_valid,
    output logic [HELD_W-1:0]       samples_held
);

    // controller <-> datapath
    cmd_t                          cmd;
    stat_t                         stat;
    logic [$clog2(MAX_WINDOW)-1:0] idx;

    svf_ctrl #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .stat     (stat),
        .cmd      (cmd),
        .idx      (idx)
    );

    // ring RAM, MAC lanes, divider and output register
    svf_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .idx            (idx),
        .stat           (stat),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .stamp_us       (stamp_us),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .vel_x          (vel_x),
        .vel_y          (vel_y),
        .vel_z          (vel_z),
        .fit_valid      (fit_valid),
        .samples_held   (samples_held)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pushes and clears into the velocity fit core and checks every output
// word against a 128-bit least-squares slope predictor held in a scoreboard.
// The run goes through several window sizes, random bursts and stalls, and a
// long output hold-off.
// ----------------------------------------------------------------------------
module testbench
    import svf_pkg::*;
();

    localparam int   RING      = 16;
    localparam longint CYCLE_LIMIT = 12000000;
    localparam logic signed [127:0] VEL_MAX = 128'sh7FFFFFFF;
    localparam logic signed [127:0] VEL_MIN = -128'sh80000000;

    typedef struct packed {
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic signed [VEL_W-1:0] vz;
        logic                    ok;
        logic [HELD_W-1:0]       held;
    } fit_word_t;

    // Fit predictor plus queue of expected output words.
    class fit_scoreboard;
        logic signed [POS_W-1:0] ring_pos[3][RING];
        logic [STAMP_W-1:0]      ring_stamp[RING];
        int unsigned             oldest;
        int unsigned             count;
        logic [CFG_W-1:0]        win_reg;
        fit_word_t               fits_due[$];
        int                      mismatches;

        function new();
            oldest = 0;
            count = 0;
            win_reg = WIN_RESET;
            mismatches = 0;
        endfunction

        function void note_word(logic act, logic signed [POS_W-1:0] px,
                                logic signed [POS_W-1:0] py,
                                logic signed [POS_W-1:0] pz,
                                logic [STAMP_W-1:0] stamp);
            fit_word_t w;
            int unsigned lim, slot, s;
            logic signed [127:0] sum_t, sum_tt, n, den, num, q, t;
            logic signed [127:0] sum_p[3], sum_tp[3];
            logic signed [31:0] vel[3];
            w = '0;
            if (act == ACT_CLEAR) begin
                oldest = 0;
                count = 0;
                fits_due = {fits_due, w};
                return;
            end
            lim = win_reg;
            if (lim < WIN_MIN) lim = WIN_MIN;
            if (lim > RING) lim = RING;
            if (count >= lim) begin
                oldest = (oldest + count - lim + 1) % RING;
                count = lim - 1;
            end
            slot = (oldest + count) % RING;
            ring_pos[0][slot] = px;
            ring_pos[1][slot] = py;
            ring_pos[2][slot] = pz;
            ring_stamp[slot] = stamp;
            count++;
            w.held = count[HELD_W-1:0];
            if (count >= 2) begin
                sum_t = 0;
                sum_tt = 0;
                for (int a = 0; a < 3; a++) begin
                    sum_p[a] = 0;
                    sum_tp[a] = 0;
                end
                for (int i = 0; i < count; i++) begin
                    s = (oldest + i) % RING;
                    t = $signed({88'd0, ring_stamp[s]}) - $signed({88'd0, ring_stamp[oldest]});
                    sum_t += t;
                    sum_tt += t * t;
                    for (int a = 0; a < 3; a++) begin
                        sum_p[a] += 128'(ring_pos[a][s]);
                        sum_tp[a] += t * 128'(ring_pos[a][s]);
                    end
                end
                n = count;
                den = n * sum_tt - sum_t * sum_t;
                if (den > 0) begin
                    for (int a = 0; a < 3; a++) begin
                        num = (n * sum_tp[a] - sum_t * sum_p[a]) * 128'sd1000000;
                        q = num / den;
                        if (q > VEL_MAX) q = VEL_MAX;
                        if (q < VEL_MIN) q = VEL_MIN;
                        vel[a] = q[31:0];
                    end
                    w.vx = vel[0];
                    w.vy = vel[1];
                    w.vz = vel[2];
                    w.ok = 1'b1;
                end
            end
            fits_due = {fits_due, w};
        endfunction

        function void check_word(fit_word_t got);
            fit_word_t exp_w;
            if (fits_due.size() == 0) begin
                $display("%0t: unexpected output word %h", $time, got);
                mismatches++;
                return;
            end
            exp_w = fits_due[0];
            fits_due.delete(0);
            if (got.vx !== exp_w.vx) begin
                $display("%0t: vel_x expected %h got %h", $time, exp_w.vx, got.vx);
                mismatches++;
            end
            if (got.vy !== exp_w.vy) begin
                $display("%0t: vel_y expected %h got %h", $time, exp_w.vy, got.vy);
                mismatches++;
            end
            if (got.vz !== exp_w.vz) begin
                $display("%0t: vel_z expected %h got %h", $time, exp_w.vz, got.vz);
                mismatches++;
            end
            if (got.ok !== exp_w.ok) begin
                $display("%0t: fit_valid expected %b got %b", $time, exp_w.ok, got.ok);
                mismatches++;
            end
            if (got.held !== exp_w.held) begin
                $display("%0t: samples_held expected %0d got %0d", $time, exp_w.held,
                         got.held);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic [CFG_W-1:0] cfg_write_data;
    logic in_valid, in_stall, action;
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
    logic [STAMP_W-1:0] stamp_us;
    logic out_valid, out_stall;
    logic signed [VEL_W-1:0] vel_x, vel_y, vel_z;
    logic fit_valid;
    logic [HELD_W-1:0] samples_held;

    fit_scoreboard sb;
    longint cycles;
    bit hold_req;       // ask the receiver for one long hold-off
    logic [STAMP_W-1:0] clock_us;   // running sample time

    sliding_window_velocity_fit_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .pos_z(pos_z),
        .stamp_us(stamp_us),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .vel_x(vel_x),
        .vel_y(vel_y),
        .vel_z(vel_z),
        .fit_valid(fit_valid),
        .samples_held(samples_held)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: any hang ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[sliding_window_velocity_fit_core] ERROR");
            $finish;
        end
    end

    // Output monitor: values sampled before this edge's updates land.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word('{vel_x, vel_y, vel_z, fit_valid, samples_held});
    end

    // Receiver stall pattern; mode changes now and then, plus one long hold.
    initial
    begin
        int mode;
        int left;
        out_stall = 1'b0;
        mode = 0;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (4000) @(posedge clk);
                hold_req = 0;
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 400);
            end
            left--;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 0);
                default: out_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Sender state: words left in the current burst.
    int burst_left;

    // Offer one word and hold it until accepted; valid stays up inside a burst.
    task automatic send_word(logic act, logic signed [POS_W-1:0] px,
                             logic signed [POS_W-1:0] py,
                             logic signed [POS_W-1:0] pz,
                             logic [STAMP_W-1:0] stamp);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 30)) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        action <= act;
        pos_x <= px;
        pos_y <= py;
        pos_z <= pz;
        stamp_us <= stamp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_word(act, px, py, pz, stamp);
        burst_left--;
    endtask

    // Drain the block, then write the window size.
    task automatic set_window(logic [CFG_W-1:0] size);
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.fits_due.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= size;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sb.win_reg = size;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom_range(0, 65536 * 20)) - 32'sd655360;
        endcase
    endfunction

    task automatic push_random();
        if ($urandom_range(0, 19) == 0)
            clock_us = STAMP_W'({$urandom, $urandom});
        else if ($urandom_range(0, 29) == 0)
            clock_us = clock_us - $urandom_range(1, 5000);
        else
            clock_us = clock_us + $urandom_range(0, 40000);
        send_word(ACT_PUSH, rand_pos(), rand_pos(), rand_pos(), clock_us);
    endtask

    initial
    begin
        logic [CFG_W-1:0] sizes[8];
        sb = new();
        cycles = 0;
        hold_req = 0;
        burst_left = 0;
        clock_us = 40'd1000;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        in_valid = 1'b0;
        action = ACT_PUSH;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        stamp_us = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: lone sample, clear, extremes, equal stamps, backwards time.
        send_word(ACT_PUSH, 32'sh7FFFFFFF, 32'sh80000000, 0, 40'd0);
        send_word(ACT_CLEAR, 0, 0, 0, 40'd0);
        send_word(ACT_PUSH, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 40'd0);
        send_word(ACT_PUSH, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 40'd1);
        send_word(ACT_PUSH, 32'sh12345, -32'sh10000, 0, 40'd1);
        send_word(ACT_CLEAR, 0, 0, 0, 40'hFF_FFFF_FFFF);
        send_word(ACT_PUSH, 32'sh10000, 0, 0, 40'd500);
        send_word(ACT_PUSH, 32'sh20000, 0, 0, 40'd500);      // zero denominator
        send_word(ACT_PUSH, 32'sh30000, 0, 0, 40'd100);      // stamp goes back
        send_word(ACT_CLEAR, 0, 0, 0, 40'd0);
        send_word(ACT_PUSH, 0, 32'sh7FFFFFFF, 0, 40'hFF_FFFF_FFFF);
        send_word(ACT_PUSH, 0, 32'sh80000000, 0, 40'd0);
        send_word(ACT_PUSH, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F, 40'h55_5555_5555);
        for (int i = 0; i < 6; i++)
            push_random();

        // Shrink below the number of samples held, then sizes in and outside the legal range.
        sizes = '{5'd2, 5'd0, 5'd31, 5'd1, 5'd17, 5'd16, 5'd5, 5'd9};
        foreach (sizes[k])
        begin
            set_window(sizes[k]);
            for (int i = 0; i < 8; i++)
                push_random();
        end

        // Long output hold-off while words keep coming.
        set_window(5'd3);
        hold_req = 1;
        for (int i = 0; i < 12; i++)
            push_random();

        // Random phases.
        for (int ph = 0; ph < 14; ph++)
        begin
            set_window(ph % 4 == 0 ? 5'($urandom_range(0, 31)) : 5'($urandom_range(2, 8)));
            for (int i = 0; i < 45; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                    send_word(ACT_CLEAR, $urandom, $urandom, $urandom,
                              STAMP_W'({$urandom, $urandom}));
                else
                    push_random();
            end
        end

        in_valid <= 1'b0;
        while (sb.fits_due.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0)
            $display("[sliding_window_velocity_fit_core] OK");
        else
            $display("[sliding_window_velocity_fit_core] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
design/svf_pkg.sv
design/svf_ram.sv
design/svf_div.sv
design/svf_dp.sv
design/svf_ctrl.sv
design/sliding_window_velocity_fit_core.sv
tb/testbench.sv
